// ----- rtl/mu7_pkg.sv -----
package mu7_pkg;

    localparam int BURST_MAX = 5;
    localparam int BURST_IDX_W = $clog2(BURST_MAX + 1);

    localparam logic [6:0] CH_AMP   = 7'h26;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_TILDE = 7'h7E;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_byte;
        logic       run_end;
        logic       name_end;
    } out_item_t;

    typedef struct packed {
        logic       in_base64;
        logic [3:0] leftover_bits;
        logic [2:0] leftover_count;
    } enc_state_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][6:0] bytes;
        logic [BURST_IDX_W-1:0]    count;
        logic                      last;
    } burst_t;

    // base64 alphabet with ',' in place of '/'
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h61 + {1'b0, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 7'h30 + {1'b0, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2C;
        end
        return c;
    endfunction

    function automatic logic is_direct(input logic [15:0] u);
        return (u >= {9'd0, CH_SPACE}) && (u <= {9'd0, CH_TILDE}) && (u != {9'd0, CH_AMP});
    endfunction

    function automatic logic [2:0] clamp_count(input logic [2:0] c);
        return (c > 3'd4) ? 3'd4 : c;
    endfunction

endpackage

// ----- rtl/mu7_pack.sv -----
module mu7_pack
    import mu7_pkg::*;
(
    input  in_item_t   item,
    input  enc_state_t state_cur,
    output burst_t     burst,
    output enc_state_t state_next
);

    logic                      direct;
    logic                      b64;
    logic [3:0]                lb;
    logic [2:0]                lc;
    logic [2:0]                cc;
    logic [BURST_IDX_W-1:0]    k;
    logic [BURST_MAX-1:0][6:0] bytes;
    logic                      do_pack;
    logic                      opening;
    logic [3:0]                pk_bits;
    logic [2:0]                pk_cnt;
    logic [19:0]               acc;
    logic [4:0]                n;
    logic [1:0]                nsext;
    logic [4:0]                sh;
    logic [4:0]                rem;
    logic [3:0]                mask;
    logic [5:0]                pad;

    always_comb begin
        direct  = is_direct(item.code_unit);
        b64     = state_cur.in_base64;
        lb      = state_cur.leftover_bits;
        lc      = state_cur.leftover_count;
        k       = '0;
        bytes   = '0;
        do_pack = 1'b0;
        opening = 1'b0;
        pk_bits = '0;
        pk_cnt  = '0;
        acc     = '0;
        n       = '0;
        nsext   = '0;
        sh      = '0;
        rem     = '0;
        mask    = '0;
        pad     = '0;
        cc      = '0;

        // close of an open run ahead of a printable unit
        if (b64 && direct) begin
            cc = clamp_count(lc);
            if (cc != 3'd0) begin
                pad = 6'({2'b00, lb} << (3'd6 - cc));
                bytes[k] = sextet_char(pad);
                k = k + 1'b1;
            end
            bytes[k] = CH_DASH;
            k = k + 1'b1;
            b64 = 1'b0;
            lb  = '0;
            lc  = '0;
        end

        if (direct) begin
            bytes[k] = item.code_unit[6:0];
            k = k + 1'b1;
        end else if (!b64 && item.code_unit == {9'd0, CH_AMP}) begin
            bytes[k] = CH_AMP;
            k = k + 1'b1;
            bytes[k] = CH_DASH;
            k = k + 1'b1;
        end else begin
            if (!b64) begin
                bytes[k] = CH_AMP;
                k = k + 1'b1;
                opening = 1'b1;
            end
            do_pack = 1'b1;
        end

        if (do_pack) begin
            pk_bits = opening ? 4'd0 : lb;
            pk_cnt  = opening ? 3'd0 : clamp_count(lc);
            acc     = {pk_bits, item.code_unit};
            n       = 5'd16 + {2'b00, pk_cnt};
            nsext   = (n >= 5'd18) ? 2'd3 : 2'd2;
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < nsext) begin
                    sh = n - 5'd6 - 5'(6 * i);
                    bytes[k] = sextet_char(6'(acc >> sh));
                    k = k + 1'b1;
                end
            end
            rem  = (nsext == 2'd3) ? n - 5'd18 : n - 5'd12;
            mask = (rem >= 5'd4) ? 4'hF : 4'((5'd1 << rem) - 5'd1);
            b64  = 1'b1;
            lb   = acc[3:0] & mask;
            lc   = rem[2:0];
        end

        // end of name flushes whatever run is still open
        if (item.last_unit && b64) begin
            cc = clamp_count(lc);
            if (cc != 3'd0) begin
                pad = 6'({2'b00, lb} << (3'd6 - cc));
                bytes[k] = sextet_char(pad);
                k = k + 1'b1;
            end
            bytes[k] = CH_DASH;
            k = k + 1'b1;
        end

        if (item.last_unit) begin
            b64 = 1'b0;
            lb  = '0;
            lc  = '0;
        end
    end

    assign burst.bytes = bytes;
    assign burst.count = k;
    assign burst.last  = item.last_unit;

    assign state_next.in_base64      = b64;
    assign state_next.leftover_bits  = lb;
    assign state_next.leftover_count = lc;

endmodule

// ----- rtl/mu7_serial.sv -----
module mu7_serial
    import mu7_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load_valid,
    output logic      load_ready,
    input  burst_t    load_burst,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    burst_t                 burst_reg;
    logic                   vld_reg;
    logic [BURST_IDX_W-1:0] idx_reg;
    logic                   at_last;
    logic                   fire;

    assign at_last    = (idx_reg == burst_reg.count - 1'b1);
    assign fire       = vld_reg && m_ready;
    assign load_ready = !vld_reg || (fire && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end else if (load_valid && load_ready) begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end else if (fire && at_last) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end else if (fire) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            burst_reg <= load_burst;
        end
    end

    assign m_valid         = vld_reg;
    assign m_data.out_byte = burst_reg.bytes[idx_reg[2:0]];
    assign m_data.run_end  = at_last;
    assign m_data.name_end = at_last && burst_reg.last;

endmodule

// ----- rtl/modified_utf7_encoder.sv -----
// Encodes a mailbox name, one UTF-16 code unit per input transfer, into IMAP
// modified UTF-7 ASCII, one byte per output transfer. An input transfer is
// taken in every cycle while there is room; each unit yields 1 to 5 bytes
// (2 or 3 inside a base64 run, up to 5 when a run closes at the end of
// the name), and the byte port moves one byte per cycle while m_ready is
// high. A unit is first registered in in_reg; its bytes are then loaded
// into the serializer's burst register, which drives m_valid. run_end marks
// the last byte of each unit and name_end the last byte of the name; after
// a unit flagged last_unit the encoder is back in direct mode for the next
// name.
module modified_utf7_encoder
    import mu7_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    in_item_t   in_reg;
    logic       in_vld_reg;
    enc_state_t state_reg;
    enc_state_t state_next;
    burst_t     burst;
    logic       load_ready;
    logic       load;

    assign load    = in_vld_reg && load_ready;
    assign s_ready = aresetn && (!in_vld_reg || load_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (load) begin
                in_vld_reg <= 1'b0;
            end
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    mu7_pack u_pack (
        .item       (in_reg),
        .state_cur  (state_reg),
        .burst      (burst),
        .state_next (state_next)
    );

    mu7_serial u_serial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_vld_reg),
        .load_ready (load_ready),
        .load_burst (burst),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- rtl/mu7_checker.sv -----
module mu7_checker
    import mu7_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output transfer changed");

    // a waiting input transfer holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("stalled input transfer changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_name_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.name_end |-> m_data.run_end)
        else $error("name end without run end");

    // bytes of one unit come back to back
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_end |=> m_valid)
        else $error("gap inside the bytes of one unit");

endmodule

bind modified_utf7_encoder mu7_checker u_mu7_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
